>>> hw/rtl/bpc_pkg.sv
// shared types, constants and register codes for the barometric compensation block
`timescale 1ns / 1ps

package bpc_pkg;

	// stream and register widths
	localparam int ADC_W   = 20;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 96;
	localparam int CAL_W   = 48;
	localparam int CIDX_W  = 2;
	localparam int DIV_W   = 64;
	localparam int DEN_W   = 31;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_TEMP_CAL  = 2'd0;
	localparam logic [CIDX_W-1:0] REG_PRESS_A   = 2'd1;
	localparam logic [CIDX_W-1:0] REG_PRESS_B   = 2'd2;
	localparam logic [CIDX_W-1:0] REG_PRESS_C   = 2'd3;

	// unpacked calibration words
	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} calib_t;

	// item handed from front to back
	typedef struct packed {
		logic [31:0]      fine;
		logic [31:0]      tc;
		logic [DIV_W-1:0] num;
		logic [DEN_W-1:0] den;
	} work_t;

	// per-item info carried along the back pipeline
	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] tc;
		logic        neg;
		logic        zero;
	} side_t;

endpackage

>>> hw/rtl/bpc_queue.sv
// small fifo between the front and the back pipelines
`timescale 1ns / 1ps

module bpc_queue #(
	parameter int DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bpc_pkg::work_t  push_item,
	output logic            full,
	input  logic            pop,
	output bpc_pkg::work_t  pop_item,
	output logic            empty
);
	import bpc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	work_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/bpc_front.sv
// front pipeline: temperature path and pressure numerator and divisor
`timescale 1ns / 1ps

module bpc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpc_pkg::calib_t            calib,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [bpc_pkg::IN_W-1:0]   s_tdata,
	output logic                       push,
	output bpc_pkg::work_t             push_item,
	input  logic                       q_full
);
	import bpc_pkg::*;

	localparam int NST = 10;

	logic [NST-1:0] vld_q;
	logic           en;

	logic [ADC_W-1:0] at_s1;
	logic [ADC_W-1:0] ap_s1, ap_s2, ap_s3, ap_s4, ap_s5, ap_s6, ap_s7, ap_s8;
	logic [31:0] pa_s2, dd_s2;
	logic signed [31:0] v1_s3, m_s3;
	logic signed [31:0] fine_s4, fine_s5, fine_s6, fine_s7, fine_s8, fine_s9, fine_s10;
	logic [31:0] tc_s5, tc_s6, tc_s7, tc_s8, tc_s9, tc_s10;
	logic signed [32:0] x_s5;
	logic [63:0] xx_s6;
	logic signed [48:0] xp5_s6, xp2_s6, xp5_s7, xp2_s7;
	logic [63:0] y1_s7, xp3_s7, y_s8, xs_s8, xp1_s9, num0_s9, num_s10;
	logic [DEN_W-1:0] den_s10;

	logic signed [17:0] a_18;
	logic signed [16:0] d_17;
	logic signed [33:0] pa_34, dd_34;
	logic signed [19:0] m_20;
	logic signed [35:0] mt_36;
	logic signed [31:0] v1_32, fine_32, tcw_32, tc_32;
	logic signed [32:0] x_33;
	logic signed [65:0] xx_66;
	logic signed [48:0] xp5_49, xp2_49;
	logic signed [79:0] y1_80, xp3_80;
	logic signed [63:0] xp5_64, xp2_64, p4_64;
	logic [63:0] y_64, xs_64, xb_64, num0_64;
	logic [79:0] xp1_80;
	logic [20:0] pp_21;
	logic [75:0] num_76;

	// whole pipe moves unless the last item cannot enter the queue
	assign en       = !(vld_q[NST-1] && q_full);
	assign s_tready = en;
	assign push     = vld_q[NST-1] && !q_full;

	assign push_item.fine = fine_s10;
	assign push_item.tc   = tc_s10;
	assign push_item.num  = num_s10;
	assign push_item.den  = den_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// temperature terms
	always_comb begin
		a_18    = $signed({1'b0, at_s1[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
		d_17    = $signed({1'b0, at_s1[19:4]}) - $signed({1'b0, calib.t1});
		pa_34   = a_18 * $signed(calib.t2);
		dd_34   = d_17 * d_17;
		m_20    = $signed(dd_s2[31:12]);
		mt_36   = m_20 * $signed(calib.t3);
		v1_32   = $signed(pa_s2) >>> 11;
		fine_32 = v1_s3 + (m_s3 >>> 14);
		tcw_32  = fine_s4 * 32'sd5 + 32'sd128;
		tc_32   = tcw_32 >>> 8;
		x_33    = $signed({fine_s4[31], fine_s4}) - 33'sd128000;
	end

	// pressure offset, sensitivity and numerator
	always_comb begin
		xx_66   = x_s5 * x_s5;
		xp5_49  = x_s5 * $signed(calib.p5);
		xp2_49  = x_s5 * $signed(calib.p2);
		y1_80   = $signed(xx_s6) * $signed(calib.p6);
		xp3_80  = $signed(xx_s6) * $signed(calib.p3);
		xp5_64  = 64'(xp5_s7);
		xp2_64  = 64'(xp2_s7);
		p4_64   = 64'($signed(calib.p4));
		y_64    = y1_s7 + 64'(xp5_64 <<< 17) + 64'(p4_64 <<< 35);
		xs_64   = 64'($signed(xp3_s7) >>> 8) + 64'(xp2_64 <<< 12);
		xb_64   = 64'h0000_8000_0000_0000 + xs_s8;
		xp1_80  = xb_64 * calib.p1;
		pp_21   = 21'd1048576 - {1'b0, ap_s8};
		num0_64 = ({43'd0, pp_21} << 31) - y_s8;
		num_76  = num0_s9 * 12'd3125;
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (en) begin
			at_s1    <= s_tdata[ADC_W-1:0];
			ap_s1    <= s_tdata[2*ADC_W-1:ADC_W];
			pa_s2    <= pa_34[31:0];
			dd_s2    <= dd_34[31:0];
			ap_s2    <= ap_s1;
			v1_s3    <= v1_32;
			m_s3     <= mt_36[31:0];
			ap_s3    <= ap_s2;
			fine_s4  <= fine_32;
			ap_s4    <= ap_s3;
			fine_s5  <= fine_s4;
			tc_s5    <= tc_32;
			x_s5     <= x_33;
			ap_s5    <= ap_s4;
			xx_s6    <= xx_66[63:0];
			xp5_s6   <= xp5_49;
			xp2_s6   <= xp2_49;
			fine_s6  <= fine_s5;
			tc_s6    <= tc_s5;
			ap_s6    <= ap_s5;
			y1_s7    <= y1_80[63:0];
			xp3_s7   <= xp3_80[63:0];
			xp5_s7   <= xp5_s6;
			xp2_s7   <= xp2_s6;
			fine_s7  <= fine_s6;
			tc_s7    <= tc_s6;
			ap_s7    <= ap_s6;
			y_s8     <= y_64;
			xs_s8    <= xs_64;
			fine_s8  <= fine_s7;
			tc_s8    <= tc_s7;
			ap_s8    <= ap_s7;
			xp1_s9   <= xp1_80[63:0];
			num0_s9  <= num0_64;
			fine_s9  <= fine_s8;
			tc_s9    <= tc_s8;
			num_s10  <= num_76[63:0];
			den_s10  <= xp1_s9[63:33];
			fine_s10 <= fine_s9;
			tc_s10   <= tc_s9;
		end
	end

endmodule

>>> hw/rtl/bpc_back.sv
// back pipeline: bit-per-stage signed divide and pressure correction terms
`timescale 1ns / 1ps

module bpc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpc_pkg::calib_t            calib,
	output logic                       pop,
	input  bpc_pkg::work_t             pop_item,
	input  logic                       q_empty,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [bpc_pkg::OUT_W-1:0]  m_tdata,
	output logic [0:0]                 m_tuser
);
	import bpc_pkg::*;

	localparam int NST = DIV_W + 7;

	logic [NST-1:0] vld_q;
	logic           en;

	// divider stages, index 0 is the load stage
	logic [DIV_W-1:0] dn_s [DIV_W+1];
	logic [DEN_W-1:0] dr_s [DIV_W+1];
	logic [DEN_W-1:0] dd_s [DIV_W+1];
	side_t            sd_s [DIV_W+1];

	logic [63:0] p_s66, p_s67, p_s68, p_s69;
	side_t       sd_s66, sd_s67, sd_s68, sd_s69, sd_s70;
	logic [63:0] ll_s67, w2_s67, w2_s68, hh_s68, w1_s69, w2_s69, sum_s70;
	logic [31:0] hl_s67;
	logic [31:0] pres_s71, fine_s71, tc_s71;
	logic        pvld_s71;

	logic [DIV_W-1:0] mn;
	logic [DEN_W-1:0] md;
	side_t            sd_in;
	logic signed [63:0] h_64;
	logic [63:0] ll_64, hl_64;
	logic signed [79:0] w2_80, w1_80;
	logic [63:0] sum_64, sh_64;
	logic [31:0] p7_32;

	// stall everything only when the output item is held
	assign en       = !(vld_q[NST-1] && !m_tready);
	assign pop      = en && !q_empty;
	assign m_tvalid = vld_q[NST-1];
	assign m_tdata  = {pres_s71, tc_s71, fine_s71};
	assign m_tuser  = pvld_s71;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], !q_empty};
		end
	end

	// operand magnitudes and quotient sign
	always_comb begin
		mn = pop_item.num[DIV_W-1] ? (~pop_item.num + 1'b1) : pop_item.num;
		md = pop_item.den[DEN_W-1] ? (~pop_item.den + 1'b1) : pop_item.den;
		sd_in.fine = pop_item.fine;
		sd_in.tc   = pop_item.tc;
		sd_in.neg  = pop_item.num[DIV_W-1] ^ pop_item.den[DEN_W-1];
		sd_in.zero = (pop_item.den == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s[0] <= mn;
			dr_s[0] <= '0;
			dd_s[0] <= md;
			sd_s[0] <= sd_in;
		end
	end

	// one restoring division step per stage
	for (genvar k = 0; k < DIV_W; k++) begin : g_div
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;
		always_comb begin
			trial = {dr_s[k], dn_s[k][DIV_W-1]};
			diff  = trial - {1'b0, dd_s[k]};
			ge    = (trial >= {1'b0, dd_s[k]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dn_s[k+1] <= {dn_s[k][DIV_W-2:0], ge};
				dr_s[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				dd_s[k+1] <= dd_s[k];
				sd_s[k+1] <= sd_s[k];
			end
		end
	end

	// square of p/2^13 from 32-bit halves, the p8 and p9 terms, and the final sum with the p7 offset
	always_comb begin
		h_64   = $signed(p_s66) >>> 13;
		ll_64  = h_64[31:0] * h_64[31:0];
		hl_64  = h_64[63:32] * h_64[31:0];
		w2_80  = $signed(p_s66) * $signed(calib.p8);
		w1_80  = $signed(hh_s68) * $signed(calib.p9);
		sum_64 = p_s69 + 64'($signed(w1_s69) >>> 25) + 64'($signed(w2_s69) >>> 19);
		sh_64  = 64'($signed(sum_s70) >>> 8);
		p7_32  = {{12{calib.p7[15]}}, calib.p7, 4'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s66    <= sd_s[DIV_W].neg ? (~dn_s[DIV_W] + 1'b1) : dn_s[DIV_W];
			sd_s66   <= sd_s[DIV_W];
			p_s67    <= p_s66;
			ll_s67   <= ll_64;
			hl_s67   <= hl_64[31:0];
			w2_s67   <= w2_80[63:0];
			sd_s67   <= sd_s66;
			p_s68    <= p_s67;
			hh_s68   <= ll_s67 + {hl_s67[30:0], 33'd0};
			w2_s68   <= w2_s67;
			sd_s68   <= sd_s67;
			p_s69    <= p_s68;
			w1_s69   <= w1_80[63:0];
			w2_s69   <= w2_s68;
			sd_s69   <= sd_s68;
			sum_s70  <= sum_64;
			sd_s70   <= sd_s69;
			fine_s71 <= sd_s70.fine;
			tc_s71   <= sd_s70.tc;
			pres_s71 <= sd_s70.zero ? '0 : (sh_64[31:0] + p7_32);
			pvld_s71 <= !sd_s70.zero;
		end
	end

endmodule

>>> hw/rtl/baro_pressure_temperature_compensation_top.sv
// top level: calibration registers, front pipeline, queue and back pipeline
//
//  port group    dir  payload (low bit first)
//  s_t*          in   adc_temperature[19:0], adc_pressure[39:20]
//  m_t*          out  tdata: fine_temperature, temperature_centi, pressure_q24_8
//                     tuser: pressure_valid
//  cfg_*         in   cfg_index selects the calibration word, cfg_data 48 bits
//
//  one item per cycle sustained while the output is not held; path: front pipeline, queue, back pipeline
//  the 64-step divider in the back pipeline sets the latency, one quotient bit a stage
//  front and back stall separately; the queue takes items while the output is held
//  reset clears valid bits, queue pointers and calibration words
`timescale 1ns / 1ps

module baro_pressure_temperature_compensation_top #(
	parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bpc_pkg::IN_W-1:0]    s_tdata,   // adc_temperature, adc_pressure
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bpc_pkg::OUT_W-1:0]   m_tdata,   // fine_temperature, temperature_centi,
	                                               // pressure_q24_8
	output logic [0:0]                  m_tuser,   // pressure_valid
	input  logic                        cfg_we,
	input  logic [bpc_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]   cfg_data
);
	import bpc_pkg::*;

	logic [CAL_W-1:0] tcal_q, pcal_a_q, pcal_b_q, pcal_c_q;
	calib_t           calib;
	logic             push, pop, q_full, q_empty;
	work_t            push_item, pop_item;

	// calibration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcal_q   <= '0;
			pcal_a_q <= '0;
			pcal_b_q <= '0;
			pcal_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_CAL: tcal_q   <= cfg_data;
				REG_PRESS_A:  pcal_a_q <= cfg_data;
				REG_PRESS_B:  pcal_b_q <= cfg_data;
				REG_PRESS_C:  pcal_c_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign calib.t1 = tcal_q[15:0];
	assign calib.t2 = tcal_q[31:16];
	assign calib.t3 = tcal_q[47:32];
	assign calib.p1 = pcal_a_q[15:0];
	assign calib.p2 = pcal_a_q[31:16];
	assign calib.p3 = pcal_a_q[47:32];
	assign calib.p4 = pcal_b_q[15:0];
	assign calib.p5 = pcal_b_q[31:16];
	assign calib.p6 = pcal_b_q[47:32];
	assign calib.p7 = pcal_c_q[15:0];
	assign calib.p8 = pcal_c_q[31:16];
	assign calib.p9 = pcal_c_q[47:32];

	bpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.calib     (calib),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	bpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	bpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.calib    (calib),
		.pop      (pop),
		.pop_item (pop_item),
		.q_empty  (q_empty),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> test/tb_baro_pressure_temperature_compensation_top.sv
// testbench for the barometric compensation block: directed table, then random phases
`timescale 1ns / 1ps

module tb_baro_pressure_temperature_compensation_top;
	import bpc_pkg::*;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] centi;
		logic [31:0] press;
		logic        valid;
	} comp_t;

	// directed row: calibration set, raw samples, typed result if known
	typedef struct {
		int          cal_set;
		logic [19:0] adc_t;
		logic [19:0] adc_p;
		bit          typed;
		comp_t       res;
	} row_t;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 120;
	localparam int NUM_CAL_SETS   = 5;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic [0:0]          m_tuser;
	logic                cfg_we;
	logic [CIDX_W-1:0]   cfg_index;
	logic [CAL_W-1:0]    cfg_data;

	// calibration words as the predictor sees them
	logic [CAL_W-1:0] cal_words [4];
	logic [CAL_W-1:0] cal_sets [NUM_CAL_SETS][4];

	comp_t expected_results [$];
	int    err_count = 0;
	int    idle_cycles = 0;
	int    send_idle_pct;
	int    recv_stall_pct;
	row_t  directed [$];

	baro_pressure_temperature_compensation_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] sext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// compensation of one sample pair with wrap at 32 and 64 bits
	function automatic comp_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
		logic [31:0] t1, t2, t3, a, d, m, v1, v2, fine, centi;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [63:0] x, y, w, w1, w2, h, num, ma, mb, q, pv;
		logic        na, nb;
		comp_t       r;
		t1 = {16'd0, cal_words[REG_TEMP_CAL][15:0]};
		t2 = {{16{cal_words[REG_TEMP_CAL][31]}}, cal_words[REG_TEMP_CAL][31:16]};
		t3 = {{16{cal_words[REG_TEMP_CAL][47]}}, cal_words[REG_TEMP_CAL][47:32]};
		a = ({12'd0, adc_t} >> 3) - (t1 << 1);
		m = a * t2;
		v1 = $signed(m) >>> 11;
		d = ({12'd0, adc_t} >> 4) - t1;
		m = d * d;
		m = $signed(m) >>> 12;
		m = m * t3;
		v2 = $signed(m) >>> 14;
		fine = v1 + v2;
		m = fine * 32'd5 + 32'd128;
		centi = $signed(m) >>> 8;

		p1 = {48'd0, cal_words[REG_PRESS_A][15:0]};
		p2 = sext16(cal_words[REG_PRESS_A][31:16]);
		p3 = sext16(cal_words[REG_PRESS_A][47:32]);
		p4 = sext16(cal_words[REG_PRESS_B][15:0]);
		p5 = sext16(cal_words[REG_PRESS_B][31:16]);
		p6 = sext16(cal_words[REG_PRESS_B][47:32]);
		p7 = sext16(cal_words[REG_PRESS_C][15:0]);
		p8 = sext16(cal_words[REG_PRESS_C][31:16]);
		p9 = sext16(cal_words[REG_PRESS_C][47:32]);

		x = {{32{fine[31]}}, fine} - 64'd128000;
		y = x * x * p6;
		y = y + ((x * p5) << 17);
		y = y + (p4 << 35);
		w = x * x * p3;
		w1 = $signed(w) >>> 8;
		x = w1 + ((x * p2) << 12);
		w = ((64'd1 << 47) + x) * p1;
		x = $signed(w) >>> 33;

		r.fine = fine;
		r.centi = centi;
		r.press = '0;
		r.valid = 1'b0;
		if (x != 64'd0) begin
			pv = 64'd1048576 - {44'd0, adc_p};
			num = ((pv << 31) - y) * 64'd3125;
			// signed divide, truncating toward zero
			na = num[63];
			nb = x[63];
			ma = na ? -num : num;
			mb = nb ? -x : x;
			q = ma / mb;
			if (na != nb)
				q = -q;
			h = $signed(q) >>> 13;
			w = p9 * h * h;
			w1 = $signed(w) >>> 25;
			w = p8 * q;
			w2 = $signed(w) >>> 19;
			w = q + w1 + w2;
			pv = $signed(w) >>> 8;
			pv = pv + (p7 << 4);
			r.press = pv[31:0];
			r.valid = 1'b1;
		end
		return r;
	endfunction

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		comp_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]};
			if (expected_results.size() == 0) begin
				$error("unexpected item: fine %h centi %h press %h valid %b",
					got.fine, got.centi, got.press, got.valid);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.fine !== want.fine) begin
					$error("fine_temperature exp %h got %h", want.fine, got.fine);
					err_count++;
				end
				if (got.centi !== want.centi) begin
					$error("temperature_centi exp %h got %h", want.centi, got.centi);
					err_count++;
				end
				if (got.press !== want.press) begin
					$error("pressure_q24_8 exp %h got %h", want.press, got.press);
					err_count++;
				end
				if (got.valid !== want.valid) begin
					$error("pressure_valid exp %b got %b", want.valid, got.valid);
					err_count++;
				end
			end
		end
	end

	// one sample pair through the slave port
	task automatic send_pair(input logic [19:0] adc_t, input logic [19:0] adc_p,
		input bit typed, input comp_t res);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {adc_p, adc_t};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(typed ? res : compensate(adc_t, adc_p));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// load all four calibration words while the block is idle
	task automatic load_calibration(input logic [CAL_W-1:0] w0, input logic [CAL_W-1:0] w1,
		input logic [CAL_W-1:0] w2, input logic [CAL_W-1:0] w3);
		logic [CAL_W-1:0] vals [4];
		vals = '{w0, w1, w2, w3};
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CIDX_W-1:0];
			cfg_data <= vals[i];
			cal_words[i] = vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CAL_W-1:0] rand_word();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// sample pair near typical operating range, or anywhere
	task automatic random_pair(output logic [19:0] adc_t, output logic [19:0] adc_p);
		if ($urandom_range(99) < 70) begin
			adc_t = 20'($urandom_range(600000, 400000));
			adc_p = 20'($urandom_range(500000, 200000));
		end else begin
			adc_t = 20'($urandom);
			adc_p = 20'($urandom);
		end
	endtask

	initial begin
		logic [19:0] at, ap;
		int          cur_set;
		int          pcts [4][2];
		comp_t       zero_res;
		row_t        r;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 4; i++)
			cal_words[i] = '0;

		// calibration sets: reset, typical, all ones, signed extremes, zero divisor
		cal_sets[0] = '{48'h0, 48'h0, 48'h0, 48'h0};
		cal_sets[1] = '{48'hFC18_6743_6B70, 48'h0BD0_D643_8E7D,
			48'hFFF9_008C_0B27, 48'h1770_C6F8_3C8C};
		cal_sets[2] = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
		cal_sets[3] = '{48'h7FFF_8000_FFFF, 48'h8000_7FFF_FFFF,
			48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000};
		cal_sets[4] = '{48'hFC18_6743_6B70, 48'h0BD0_D643_0000,
			48'hFFF9_008C_0B27, 48'h1770_C6F8_3C8C};

		// directed table; reset calibration gives zero divisor and zero temperature
		zero_res = '0;
		r.typed = 1'b1;
		r.res = zero_res;
		r.cal_set = 0;
		r.adc_t = 20'h00000; r.adc_p = 20'h00000; directed.push_back(r);
		r.adc_t = 20'hFFFFF; r.adc_p = 20'hFFFFF; directed.push_back(r);
		r.adc_t = 20'h80000; r.adc_p = 20'h00001; directed.push_back(r);
		r.adc_t = 20'h00001; r.adc_p = 20'h80000; directed.push_back(r);
		r.typed = 1'b0;
		for (int s = 1; s < NUM_CAL_SETS; s++) begin
			r.cal_set = s;
			r.adc_t = 20'h00000; r.adc_p = 20'h00000; directed.push_back(r);
			r.adc_t = 20'hFFFFF; r.adc_p = 20'hFFFFF; directed.push_back(r);
			r.adc_t = 20'd519888; r.adc_p = 20'd415148; directed.push_back(r);
			r.adc_t = 20'h55555; r.adc_p = 20'hAAAAA; directed.push_back(r);
			r.adc_t = 20'hAAAAA; r.adc_p = 20'h55555; directed.push_back(r);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		foreach (directed[i]) begin
			if (directed[i].cal_set != cur_set) begin
				cur_set = directed[i].cal_set;
				load_calibration(cal_sets[cur_set][0], cal_sets[cur_set][1],
					cal_sets[cur_set][2], cal_sets[cur_set][3]);
			end
			send_pair(directed[i].adc_t, directed[i].adc_p, directed[i].typed,
				directed[i].res);
		end

		// random phases with different idling and calibration
		pcts = '{'{0, 0}, '{65, 0}, '{0, 65}, '{9, 9}};
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: load_calibration(cal_sets[1][0], cal_sets[1][1],
					cal_sets[1][2], cal_sets[1][3]);
				1: load_calibration(rand_word(), rand_word(), rand_word(), rand_word());
				2: load_calibration(cal_sets[1][0] ^ 48'($urandom_range(255)),
					cal_sets[1][1] ^ 48'($urandom_range(255)),
					cal_sets[1][2] ^ 48'($urandom_range(255)),
					cal_sets[1][3] ^ 48'($urandom_range(255)));
				default: begin
					cur_set = $urandom_range(NUM_CAL_SETS - 1, 2);
					load_calibration(cal_sets[cur_set][0], cal_sets[cur_set][1],
						cal_sets[cur_set][2], cal_sets[cur_set][3]);
				end
			endcase
			send_idle_pct = pcts[ph % 4][0];
			recv_stall_pct = pcts[ph % 4][1];
			for (int n = 0; n < 50; n++) begin
				// in phase 1 after 25 pairs, the sender holds off until the pipeline has fully drained
				if (ph == 1 && n == 25) begin
					s_tvalid <= 1'b0;
					while (expected_results.size() != 0)
						@(posedge clk);
				end
				random_pair(at, ap);
				send_pair(at, ap, 1'b0, zero_res);
			end
		end

		recv_stall_pct = 0;
		wait_idle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
